FILE: hdl/slot_pool_allocator_core_assert.svh
// Assertion macros shared by the slot pool allocator RTL.
`ifndef SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low.
`define SPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while aresetn is low.
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/spa_pkg.sv
// Shared constants and controller/datapath interface types of the slot pool allocator.
`timescale 1ns / 1ps

package spa_pkg;

    localparam int POOL_SLOTS_DEF = 64;

    // Fixed field widths
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;   // live_count, active_head, active_tail

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = STATUS_W;
    localparam int M_PAD_W   = M_TDATA_W - SLOT_W - 3 * COUNT_W;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch request, read link memories
        logic commit;    // apply command, load result register
        logic relink;    // second next-link write of a free
    } spa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_free;   // pending command is a free
        logic op_ok;     // pending command will succeed
        logic out_room;  // result register can take a new result
    } spa_stat_t;

endpackage

FILE: hdl/spa_ctrl.sv
// Sequencing state machine of the slot pool allocator.
`timescale 1ns / 1ps
`include "slot_pool_allocator_core_assert.svh"

module spa_ctrl
    import spa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  spa_stat_t stat,
    output spa_cmd_t  cmd,
    output logic      s_tready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold here while the previous result is still unclaimed
                if (stat.out_room) begin
                    cmd.commit = 1'b1;
                    state_next = (stat.is_free && stat.op_ok) ? S_LINK : S_IDLE;
                end
            end
            S_LINK: begin
                cmd.relink = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = ready_reg;

    `SPA_ASSERT_NOW(a_ready_only_idle, ready_reg, state_reg == S_IDLE, "ready outside idle")
    `SPA_ASSERT_NEXT(a_relink_after_free, cmd.commit && stat.is_free && stat.op_ok, cmd.relink, "free without relink")

endmodule

FILE: hdl/spa_dp.sv
// Link memories, list pointers and result register of the slot pool allocator.
`timescale 1ns / 1ps
`include "slot_pool_allocator_core_assert.svh"

module spa_dp
    import spa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spa_cmd_t             cmd,
    output spa_stat_t            stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int LW = $clog2(POOL_SLOTS + 1);   // link width, holds the empty mark
    localparam int IW = $clog2(POOL_SLOTS);       // memory index width
    localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

    typedef logic [LW-1:0] link_t;
    typedef logic [IW-1:0] idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

    // Link memories
    link_t next_mem [POOL_SLOTS];
    link_t prev_mem [POOL_SLOTS];
    logic  use_mem  [POOL_SLOTS];

    // Request and read data
    logic              cmd_reg;
    logic [SLOT_W-1:0] req_reg;
    idx_t              addr_reg;
    link_t             rd_next_reg, rd_prev_reg;
    logic              rd_use_reg;

    // List state
    link_t free_head_reg, free_head_next;
    link_t list_head_reg, list_head_next;
    link_t list_tail_reg, list_tail_next;
    link_t count_reg, count_next;
    link_t mark_reg, mark_next;      // slots at or above this were never touched
    link_t link_p_reg, link_p_next;
    link_t link_n_reg, link_n_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [COUNT_W-1:0] out_head_reg, out_head_next;
    logic [COUNT_W-1:0] out_tail_reg, out_tail_next;

    // Write ports
    logic  nxt_we, prv_we, use_we, use_wd;
    idx_t  nxt_wa, prv_wa, use_wa;
    link_t nxt_wd, prv_wd;

    logic              in_cmd;
    logic [SLOT_W-1:0] in_slot;
    idx_t              rd_addr;
    link_t             req_link, eff_next, p_link, n_link;
    logic              fresh, req_in_range, alloc_ok, free_ok, op_ok, out_room;

    assign in_cmd  = s_tuser[0];
    assign in_slot = s_tdata[SLOT_W-1:0];
    assign rd_addr = in_cmd ? IW'(in_slot) : free_head_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
            rd_use_reg  <= use_mem[rd_addr];
            addr_reg    <= rd_addr;
            cmd_reg     <= in_cmd;
            req_reg     <= in_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) begin
            next_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we) begin
            prev_mem[prv_wa] <= prv_wd;
        end
        if (use_we) begin
            use_mem[use_wa] <= use_wd;
        end
    end

    // Untouched slots read as their reset contents: next is i+1, not in use.
    assign fresh        = (LW'(addr_reg) >= mark_reg);
    assign eff_next     = fresh ? (LW'(addr_reg) + LW'(1)) : rd_next_reg;
    assign req_link     = LW'(req_reg);
    assign req_in_range = (32'(req_reg) < POOL_SLOTS);
    assign alloc_ok     = (free_head_reg != NIL);
    assign free_ok      = req_in_range && !fresh && rd_use_reg;
    assign op_ok        = cmd_reg ? free_ok : alloc_ok;
    assign out_room     = !out_valid_reg || m_tready;

    // Neighbors of the slot being freed; list ends are known from head and tail.
    assign p_link = (req_link == list_head_reg) ? NIL : rd_prev_reg;
    assign n_link = (req_link == list_tail_reg) ? NIL : rd_next_reg;

    assign stat.is_free  = cmd_reg;
    assign stat.op_ok    = op_ok;
    assign stat.out_room = out_room;

    always_comb begin
        free_head_next = free_head_reg;
        list_head_next = list_head_reg;
        list_tail_next = list_tail_reg;
        count_next     = count_reg;
        mark_next      = mark_reg;
        link_p_next    = link_p_reg;
        link_n_next    = link_n_reg;
        nxt_we = 1'b0;
        nxt_wa = free_head_reg[IW-1:0];
        nxt_wd = free_head_reg;
        prv_we = 1'b0;
        prv_wa = free_head_reg[IW-1:0];
        prv_wd = list_tail_reg;
        use_we = 1'b0;
        use_wa = addr_reg;
        use_wd = 1'b0;

        if (cmd.commit && op_ok) begin
            if (!cmd_reg) begin
                // allocate: pop free head, append at active tail
                use_we = 1'b1;
                use_wa = free_head_reg[IW-1:0];
                use_wd = 1'b1;
                prv_we = 1'b1;
                prv_wa = free_head_reg[IW-1:0];
                prv_wd = list_tail_reg;
                if ((list_tail_reg != NIL) && (list_head_reg != NIL)) begin
                    nxt_we = 1'b1;
                    nxt_wa = list_tail_reg[IW-1:0];
                    nxt_wd = free_head_reg;
                end else begin
                    list_head_next = free_head_reg;
                end
                list_tail_next = free_head_reg;
                free_head_next = eff_next;
                count_next     = count_reg + LW'(1);
                if (fresh) begin
                    mark_next = mark_reg + LW'(1);
                end
            end else begin
                // free: push on free head now, patch predecessor next cycle
                use_we = 1'b1;
                use_wa = addr_reg;
                use_wd = 1'b0;
                nxt_we = 1'b1;
                nxt_wa = addr_reg;
                nxt_wd = free_head_reg;
                if (n_link != NIL) begin
                    prv_we = 1'b1;
                    prv_wa = n_link[IW-1:0];
                    prv_wd = p_link;
                end else begin
                    list_tail_next = p_link;
                end
                if (p_link == NIL) begin
                    list_head_next = n_link;
                end
                free_head_next = req_link;
                if (count_reg != '0) begin
                    count_next = count_reg - LW'(1);
                end
                link_p_next = p_link;
                link_n_next = n_link;
            end
        end

        if (cmd.relink && (link_p_reg != NIL)) begin
            nxt_we = 1'b1;
            nxt_wa = link_p_reg[IW-1:0];
            nxt_wd = link_n_reg;
        end
    end

    always_comb begin
        out_valid_next  = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_status_next = op_ok ? ST_OK : (cmd_reg ? ST_NOT_ALLOC : ST_FULL);
        out_slot_next   = '0;
        if (op_ok) begin
            out_slot_next = cmd_reg ? req_reg : SLOT_W'(free_head_reg);
        end
        out_count_next = COUNT_W'(count_next);
        out_head_next  = COUNT_W'(list_head_next);
        out_tail_next  = COUNT_W'(list_tail_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            list_head_reg <= NIL;
            list_tail_reg <= NIL;
            count_reg     <= '0;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            list_tail_reg <= list_tail_next;
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        link_p_reg <= link_p_next;
        link_n_reg <= link_n_next;
        if (cmd.commit) begin
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_count_reg  <= out_count_next;
            out_head_reg   <= out_head_next;
            out_tail_reg   <= out_tail_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_tail_reg, out_head_reg, out_count_reg,
                       out_slot_reg};

    `SPA_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_reg) <= POOL_SLOTS, "live count beyond pool")
    `SPA_ASSERT_NOW(a_empty_lists, count_reg == '0, (list_head_reg == NIL) && (list_tail_reg == NIL), "empty pool with active list")
    `SPA_ASSERT_NOW(a_commit_room, cmd.commit, !out_valid_reg || m_tready, "unclaimed result overwritten")

endmodule

FILE: hdl/slot_pool_allocator_core.sv
// Top level of the slot pool allocator: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Slot pool allocator. Hands out slot indices 0..POOL_SLOTS-1 from a free
// list (index order after reset) and keeps allocated slots on a doubly
// linked active list in allocation order. A transfer on the s_ side with
// s_tuser = 0 allocates (takes the free head, appends it at the active
// tail); s_tuser = 1 frees the slot in s_tdata (unlinks it, pushes it onto
// the free head, so it is the next one handed out). Every command produces
// exactly one m_ transfer: status in m_tuser (0 ok, 1 pool full, 2 slot
// not allocated or out of range), then granted slot (zero on error), live
// count, active head and active tail after the step, where POOL_SLOTS
// marks an empty list. Count, head and tail are reported in 7 bits.
// Timing: after the accept the command executes and loads the result
// register, waiting while an earlier result is unclaimed. An allocate or
// a failed command then reopens the input; a successful free first passes
// through a relink state that patches its predecessor's next link. The pace
// is set by the registered read of the link memories followed by the write
// port of the next-link memory, which a free needs twice. One command is in
// flight at a time; a pending result in the output register does not block
// the next accept, but a second result waits until the first is taken. No
// clearing pass after reset: a fill mark tracks which slots were ever
// touched, and untouched slots read as their reset links, so s_tready rises
// in the cycle after reset is released.

module slot_pool_allocator_core
    import spa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [5:0] slot_to_free, [7:6] zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [5:0] granted_slot, [12:6] live_count,
                                            // [19:13] active_head, [26:20] active_tail,
                                            // [31:27] zero
    output logic [M_TUSER_W-1:0] m_tuser    // [1:0] status
);

    spa_cmd_t  cmd;
    spa_stat_t stat;

    // Sequencer: accept, execute, and the extra relink state of a free
    spa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    // Link memories, list pointers and the result register
    spa_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: test/slot_pool_allocator_core_tb.sv
// Self-checking testbench for slot_pool_allocator_core: predicted results vs. m_ transfers.
`timescale 1ns / 1ps

module slot_pool_allocator_core_tb;
    import spa_pkg::*;

    localparam int        SLOTS      = POOL_SLOTS_DEF;
    localparam logic [6:0] NO_SLOT   = 7'(SLOTS);
    localparam int        QUIET_MAX  = 5000;
    localparam int        MAX_REPORT = 10;

    typedef enum logic { CMD_ALLOC = 1'b0, CMD_FREE = 1'b1 } pool_cmd_e;
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_FULL          = 2'd1,
        ST_NOT_ALLOCATED = 2'd2
    } pool_status_e;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] slot;
        logic [6:0] live;
        logic [6:0] head;
        logic [6:0] tail;
    } pool_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    slot_pool_allocator_core #(.POOL_SLOTS(SLOTS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Predicted pool state
    logic [6:0] next_link [0:SLOTS-1];
    logic [6:0] prev_link [0:SLOTS-1];
    logic       in_use    [0:SLOTS-1];
    logic [6:0] free_head;
    logic [6:0] list_head;
    logic [6:0] list_tail;
    logic [6:0] live_slots;

    pool_result_t owed_results[$];
    int           mismatches    = 0;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           quiet_cycles  = 0;

    task automatic pool_clear();
        for (int i = 0; i < SLOTS; i++) begin
            next_link[i] = 7'(i + 1);
            prev_link[i] = NO_SLOT;
            in_use[i]    = 1'b0;
        end
        free_head  = '0;
        list_head  = NO_SLOT;
        list_tail  = NO_SLOT;
        live_slots = '0;
    endtask

    // Applies one command to the predicted pool and returns the result it owes.
    function automatic pool_result_t apply_pool_cmd(pool_cmd_e cmd, logic [5:0] req);
        pool_result_t r;
        logic [6:0]   s;
        logic [6:0]   p;
        logic [6:0]   n;
        r = '0;
        if (cmd == CMD_ALLOC) begin
            s = free_head;
            if (s >= NO_SLOT) begin
                r.status = ST_FULL;
            end else begin
                free_head = next_link[s[5:0]];
                if (free_head < NO_SLOT) prev_link[free_head[5:0]] = NO_SLOT;
                prev_link[s[5:0]] = list_tail;
                if (list_tail < NO_SLOT && list_head < NO_SLOT) begin
                    next_link[list_tail[5:0]] = s;
                end else begin
                    list_head = s;
                end
                list_tail         = s;
                next_link[s[5:0]] = NO_SLOT;
                in_use[s[5:0]]    = 1'b1;
                live_slots        = live_slots + 7'd1;
                r.slot            = s[5:0];
            end
        end else begin
            if (int'(req) >= SLOTS || !in_use[req]) begin
                r.status = ST_NOT_ALLOCATED;
            end else begin
                p = prev_link[req];
                n = next_link[req];
                if (p < NO_SLOT) next_link[p[5:0]] = n;
                else list_head = n;
                if (n < NO_SLOT) prev_link[n[5:0]] = p;
                else list_tail = p;
                if (free_head < NO_SLOT) prev_link[free_head[5:0]] = {1'b0, req};
                next_link[req] = free_head;
                prev_link[req] = NO_SLOT;
                free_head      = {1'b0, req};
                in_use[req]    = 1'b0;
                if (live_slots > 0) live_slots = live_slots - 7'd1;
                r.slot = req;
            end
        end
        r.live = live_slots;
        r.head = list_head;
        r.tail = list_tail;
        return r;
    endfunction

    // Random member of the active list; only called with live_slots > 0.
    function automatic logic [5:0] pick_live_slot();
        int         k;
        logic [6:0] s;
        k = $urandom_range(0, int'(live_slots) - 1);
        s = list_head;
        repeat (k) s = next_link[s[5:0]];
        return s[5:0];
    endfunction

    task automatic send_cmd(input pool_cmd_e cmd, input logic [5:0] req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        owed_results.push_back(apply_pool_cmd(cmd, req));
    endtask

    // Drop the input and wait until every owed result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        pool_result_t want;
        pool_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser[1:0];
            got.slot   = m_tdata[5:0];
            got.live   = m_tdata[12:6];
            got.head   = m_tdata[19:13];
            got.tail   = m_tdata[26:20];
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("unexpected result: status %0d slot %0d live %0d head %0d tail %0d",
                             got.status, got.slot, got.live, got.head, got.tail);
            end else begin
                want = owed_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display({"result mismatch: exp status %0d slot %0d live %0d head %0d",
                                  " tail %0d, got %0d %0d %0d %0d %0d"},
                                 want.status, want.slot, want.live, want.head, want.tail,
                                 got.status, got.slot, got.live, got.head, got.tail);
                end
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Single slot, head/middle/tail unlink, LIFO reuse, frees of idle slots.
    task automatic test_list_edges();
        send_cmd(CMD_ALLOC, 6'h3F);
        send_cmd(CMD_FREE, 6'd0);
        send_cmd(CMD_FREE, 6'd0);
        send_cmd(CMD_FREE, 6'd63);
        repeat (4) send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_FREE, 6'd2);
        send_cmd(CMD_FREE, 6'd0);
        send_cmd(CMD_FREE, 6'd3);
        send_cmd(CMD_ALLOC, 6'h2A);
        send_cmd(CMD_FREE, 6'd1);
        send_cmd(CMD_FREE, 6'd1);
        send_cmd(CMD_FREE, 6'd3);
        send_cmd(CMD_ALLOC, 6'h15);
        send_cmd(CMD_ALLOC, 6'h3F);
        send_cmd(CMD_FREE, 6'd4);
    endtask

    // Fill to full, allocate past full, then drain in random order.
    task automatic test_pool_exhaust();
        while (live_slots < NO_SLOT) send_cmd(CMD_ALLOC, 6'($urandom));
        repeat (2) send_cmd(CMD_ALLOC, 6'($urandom));
        while (live_slots > 0) send_cmd(CMD_FREE, pick_live_slot());
        send_cmd(CMD_FREE, 6'd63);
        send_cmd(CMD_ALLOC, 6'd0);
    endtask

    task automatic run_random_cmds(input int count, input int alloc_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < alloc_pct)
                send_cmd(CMD_ALLOC, 6'($urandom));
            else if (live_slots > 0 && $urandom_range(0, 99) < 85)
                send_cmd(CMD_FREE, pick_live_slot());
            else
                send_cmd(CMD_FREE, 6'($urandom));
        end
    endtask

    // Random traffic under each idle/stall mix; the alloc-heavy half runs into full.
    task automatic test_random_traffic();
        int idle_mix  [4] = '{0, 64, 0, 35};
        int stall_mix [4] = '{0, 0, 64, 35};
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            send_idle_pct = idle_mix[ph];
            stall_pct     = stall_mix[ph];
            run_random_cmds(170, 80);
            run_random_cmds(150, 25);
        end
    endtask

    initial begin
        pool_clear();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_list_edges();
        test_pool_exhaust();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
